>>> src/ultrasonic_parking_gap_detector_assert.svh
// Assertion macros for the parking gap detector checks.
// Used by the port checker; depends on nothing else.
`ifndef ULTRASONIC_PARKING_GAP_DETECTOR_ASSERT_SVH
`define ULTRASONIC_PARKING_GAP_DETECTOR_ASSERT_SVH

// same-cycle implication
`define UPGD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("parking gap detector check failed");

// next-cycle implication
`define UPGD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("parking gap detector check failed");

`endif

>>> src/upgd_pkg.sv
// Shared types and constants for the parking gap detector.
// No dependencies; imported by the datapath and controller.
package upgd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GAP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TYPE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_WIDTH = 2'd2;

  localparam logic [15:0] GAP_THRESHOLD_RST = 16'd2000;
  localparam logic [1:0]  SLOT_TYPE_RST     = 2'd0;
  localparam logic [12:0] VEHICLE_WIDTH_RST = 13'd1800;

  localparam logic [1:0] SLOT_PARALLEL      = 2'd0;
  localparam logic [1:0] SLOT_PERPENDICULAR = 2'd1;

  localparam int DIST_W      = 16;
  localparam int DEPTH_W     = 14;
  localparam int WIDTH_OUT_W = 17;
  localparam int CX_OUT_W    = 18;
  localparam int CY_W        = 15;
  localparam int CORNER_W    = 20;
  localparam int TDATA_W     = 104;
  localparam int TUSER_W     = 3;

  localparam int MIN_GAP     = 5;
  localparam int SPACING     = 100;
  localparam int RANGE_LIMIT = 10000;
  localparam int ROT_SHIFT   = 16;
  localparam int ROUND_HALF  = 32768;
  localparam logic signed [16:0] HALF_SQRT2_Q16 = 17'sd46341;

  localparam logic [1:0] LAST_CORNER = 2'd3;

  typedef struct packed {
    logic       take;      // input channel open
    logic       div_step;
    logic       prep;
    logic       mul_a;
    logic       mul_b;
    logic       emit;
    logic       last;
    logic [1:0] corner;
  } cmd_t;

  typedef struct packed {
    logic end_accept;  // scan_end reading transferred this cycle
    logic div_done;
    logic found;
    logic out_free;
  } status_t;

  // corner sign patterns, 1 = negative offset
  function automatic logic neg_x(logic [1:0] st, logic [1:0] k);
    if (st == SLOT_PARALLEL) return (k == 2'd0) || (k == 2'd3);
    return !k[1];
  endfunction

  function automatic logic neg_y(logic [1:0] st, logic [1:0] k);
    if (st == SLOT_PARALLEL) return !k[1];
    return (k == 2'd0) || (k == 2'd3);
  endfunction

endpackage

>>> src/ultrasonic_parking_gap_detector.sv
// Top level of the parking gap detector: controller plus datapath.
// Depends on upgd_pkg, upgd_ctrl and upgd_datapath.
//
// One distance reading (mm) is taken per cycle while a scan is running. The
// reading carrying tlast closes the scan; the block then stops taking input
// for the end-of-scan work: a restoring divider for the mean depth, one bit
// per cycle for each bit of the run sum (24 bits at MAX_READINGS = 1024),
// then slot setup, then for each corner the two rotation products in turn
// and the output register, which waits while the output side stalls; only
// then is the next scan's first reading taken. A found slot gives four
// result transfers, one per corner, the fourth with tlast; no slot gives one
// transfer with found clear and tlast set. Configuration is written through
// the plain write port; the user must do so only while idle, as the block
// itself does not enforce it.
module ultrasonic_parking_gap_detector #(
  parameter int MAX_READINGS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [upgd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [upgd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [15:0] distance
  input  logic [upgd_pkg::DIST_W-1:0]     s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,   // scan_end
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [16:0] slot_width, [30:17] slot_depth, [48:31] center_along,
  // [63:49] center_lateral, [83:64] corner_along, [103:84] corner_lateral
  output logic [upgd_pkg::TDATA_W-1:0]    m_axis_tdata_o,
  // [0] found, [2:1] corner_index
  output logic [upgd_pkg::TUSER_W-1:0]    m_axis_tuser_o,
  output logic                            m_axis_tlast_o    // last_of_run
);
  import upgd_pkg::*;

  cmd_t    cmd;
  status_t status;

  upgd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  upgd_datapath #(
    .MAX_READINGS (MAX_READINGS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

>>> src/upgd_datapath.sv
// Datapath: run tracking, config registers, serial divider, corner math, output register.
// Depends on upgd_pkg; driven by upgd_ctrl through cmd_t / status_t.
module upgd_datapath #(
  parameter int MAX_READINGS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [upgd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [upgd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [upgd_pkg::DIST_W-1:0]         s_axis_tdata_i,
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [upgd_pkg::TDATA_W-1:0]        m_axis_tdata_o,
  output logic [upgd_pkg::TUSER_W-1:0]        m_axis_tuser_o,
  output logic                                m_axis_tlast_o,
  input  upgd_pkg::cmd_t                      cmd_i,
  output upgd_pkg::status_t                   status_o
);
  import upgd_pkg::*;

  localparam int IDX_W   = $clog2(MAX_READINGS + 1);
  localparam int START_W = $clog2(MAX_READINGS);
  localparam int LEN_W   = IDX_W;
  localparam int SUM_W   = $clog2(MAX_READINGS * (RANGE_LIMIT - 1) + 1);
  localparam int DC_W    = $clog2(SUM_W + 1);
  localparam int HW_W    = $clog2(MAX_READINGS * SPACING + 1);
  localparam int V_W     = ((HW_W > DEPTH_W) ? HW_W : DEPTH_W) + 2;
  localparam int P_W     = V_W + 17;
  localparam int CXS_W   = $clog2(MAX_READINGS + MAX_READINGS / 2 + 1);
  localparam int CXF_W   = CXS_W + 8;

  // config
  logic [15:0] gap_thr_q;
  logic [1:0]  slot_type_q;
  logic [12:0] veh_width_q;

  // scan state
  logic [IDX_W-1:0]   idx_q;
  logic               active_q;
  logic [START_W-1:0] start_q, best_start_q;
  logic [LEN_W-1:0]   len_q, best_len_q, cnt_q, best_cnt_q;
  logic [SUM_W-1:0]   sum_q, best_sum_q;

  // end-of-scan result and divider
  logic [START_W-1:0] res_start_q;
  logic [LEN_W-1:0]   res_len_q, res_cnt_q;
  logic [SUM_W-1:0]   quo_q;
  logic [LEN_W-1:0]   rem_q;
  logic [DC_W-1:0]    div_cnt_q;

  // slot geometry
  logic                      found_q;
  logic [DEPTH_W-1:0]        depth_q;
  logic [HW_W-1:0]           hw_q;
  logic signed [CORNER_W-1:0] cx_q;
  logic [CY_W-1:0]           cy_q;
  logic signed [P_W-1:0]     prod_a_q, prod_b_q;

  logic m_valid_q;

  // per-reading update
  logic               accept, in_rng, gap, near, close, take_best;
  logic               x_active;
  logic [START_W-1:0] x_start, b_start;
  logic [LEN_W-1:0]   x_len, x_cnt, b_len, b_cnt;
  logic [SUM_W-1:0]   x_sum, b_sum;

  always_comb begin
    accept   = s_axis_tvalid_i && cmd_i.take;
    in_rng   = idx_q < IDX_W'(MAX_READINGS);
    gap      = s_axis_tdata_i > gap_thr_q;
    near     = s_axis_tdata_i < DIST_W'(RANGE_LIMIT);
    x_active = active_q;
    x_start  = start_q;
    x_len    = len_q;
    x_sum    = sum_q;
    x_cnt    = cnt_q;
    if (in_rng && gap) begin
      if (!active_q) begin
        x_active = 1'b1;
        x_start  = idx_q[START_W-1:0];
        x_len    = '0;
        x_sum    = '0;
        x_cnt    = '0;
      end
      x_len = x_len + LEN_W'(1);
      if (near) begin
        x_sum = x_sum + SUM_W'(s_axis_tdata_i);
        x_cnt = x_cnt + LEN_W'(1);
      end
    end
    // strictly longer wins, so ties keep the earlier run
    close     = s_axis_tlast_i || (in_rng && !gap);
    take_best = close && x_active && (x_len > best_len_q);
    b_start   = take_best ? x_start : best_start_q;
    b_len     = take_best ? x_len   : best_len_q;
    b_sum     = take_best ? x_sum   : best_sum_q;
    b_cnt     = take_best ? x_cnt   : best_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_thr_q   <= GAP_THRESHOLD_RST;
      slot_type_q <= SLOT_TYPE_RST;
      veh_width_q <= VEHICLE_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAP_THRESHOLD: gap_thr_q   <= cfg_wdata_i;
        CFG_SLOT_TYPE:     slot_type_q <= cfg_wdata_i[1:0];
        CFG_VEHICLE_WIDTH: veh_width_q <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      active_q     <= 1'b0;
      start_q      <= '0;
      len_q        <= '0;
      sum_q        <= '0;
      cnt_q        <= '0;
      best_start_q <= '0;
      best_len_q   <= '0;
      best_sum_q   <= '0;
      best_cnt_q   <= '0;
    end else if (accept) begin
      if (s_axis_tlast_i) begin
        idx_q        <= '0;
        active_q     <= 1'b0;
        start_q      <= '0;
        len_q        <= '0;
        sum_q        <= '0;
        cnt_q        <= '0;
        best_start_q <= '0;
        best_len_q   <= '0;
        best_sum_q   <= '0;
        best_cnt_q   <= '0;
      end else begin
        if (in_rng) idx_q <= idx_q + IDX_W'(1);
        active_q     <= close ? 1'b0 : x_active;
        start_q      <= x_start;
        len_q        <= x_len;
        sum_q        <= x_sum;
        cnt_q        <= x_cnt;
        best_start_q <= b_start;
        best_len_q   <= b_len;
        best_sum_q   <= b_sum;
        best_cnt_q   <= b_cnt;
      end
    end
  end

  // restoring divider, one quotient bit per step, quotient replaces dividend in quo_q
  logic [LEN_W:0] trial;
  logic           fits;

  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    fits  = trial >= {1'b0, res_cnt_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (accept && s_axis_tlast_i) begin
      div_cnt_q <= DC_W'(SUM_W);
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q - DC_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tlast_i) begin
      res_start_q <= b_start;
      res_len_q   <= b_len;
      res_cnt_q   <= b_cnt;
      quo_q       <= b_sum;
      rem_q       <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], fits};
      rem_q <= fits ? LEN_W'(trial - {1'b0, res_cnt_q}) : trial[LEN_W-1:0];
    end
  end

  // geometry
  logic [DEPTH_W-1:0]       depth_w;
  logic [CXF_W-1:0]         cx_full;
  logic signed [V_W-1:0]    hw_s, hd_s, dx, dy, va, vb;
  logic signed [P_W-1:0]    rnd_a, rnd_b;
  logic signed [CORNER_W-1:0] cy_s, ax, ay;
  logic                     diag;

  always_comb begin
    depth_w = (res_cnt_q == '0) ? '0 : quo_q[DEPTH_W-1:0];
    cx_full = (CXF_W'(res_start_q) + CXF_W'(res_len_q >> 1)) * CXF_W'(2 * SPACING);
    diag    = (slot_type_q != SLOT_PARALLEL) && (slot_type_q != SLOT_PERPENDICULAR);
    hw_s    = $signed(V_W'(hw_q));
    hd_s    = $signed(V_W'(depth_q));
    dx      = neg_x(slot_type_q, cmd_i.corner) ? -hw_s : hw_s;
    dy      = neg_y(slot_type_q, cmd_i.corner) ? -hd_s : hd_s;
    va      = dx - dy;
    vb      = dx + dy;
    rnd_a   = (prod_a_q + P_W'(ROUND_HALF)) >>> ROT_SHIFT;
    rnd_b   = (prod_b_q + P_W'(ROUND_HALF)) >>> ROT_SHIFT;
    cy_s    = $signed(CORNER_W'(cy_q));
    ax      = diag ? cx_q + CORNER_W'(rnd_a) : cx_q + CORNER_W'(dx);
    ay      = diag ? cy_s + CORNER_W'(rnd_b) : cy_s + CORNER_W'(dy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.prep) begin
      found_q <= res_len_q >= LEN_W'(MIN_GAP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      depth_q <= depth_w;
      hw_q    <= HW_W'(res_len_q) * HW_W'(SPACING);
      cx_q    <= $signed(CORNER_W'(cx_full));
      cy_q    <= CY_W'(veh_width_q) + CY_W'(depth_w);
    end
    if (cmd_i.mul_a) prod_a_q <= P_W'(va) * P_W'(HALF_SQRT2_Q16);
    if (cmd_i.mul_b) prod_b_q <= P_W'(vb) * P_W'(HALF_SQRT2_Q16);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (found_q) begin
        m_axis_tdata_o <= {ay, ax, cy_q, cx_q[CX_OUT_W-1:0], depth_q,
                           WIDTH_OUT_W'(hw_q)};
        m_axis_tuser_o <= {cmd_i.corner, 1'b1};
        m_axis_tlast_o <= cmd_i.last;
      end else begin
        m_axis_tdata_o <= '0;
        m_axis_tuser_o <= '0;
        m_axis_tlast_o <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign s_axis_tready_o = cmd_i.take;

  always_comb begin
    status_o.end_accept = accept && s_axis_tlast_i;
    status_o.div_done   = div_cnt_q == '0;
    status_o.found      = found_q;
    status_o.out_free   = !m_valid_q || m_axis_tready_i;
  end

endmodule

>>> src/upgd_ctrl.sv
// Controller FSM: scan intake, divide, slot prep and per-corner sequencing.
// Depends on upgd_pkg; drives upgd_datapath by cmd_t, watches status_t.
module upgd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  upgd_pkg::status_t  status_i,
  output upgd_pkg::cmd_t     cmd_o
);
  import upgd_pkg::*;

  typedef enum logic [5:0] {
    ST_RUN  = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_PREP = 6'b000100,
    ST_MULA = 6'b001000,
    ST_MULB = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] corner_q, corner_d;
  logic       last;

  always_comb begin
    state_d  = state_q;
    corner_d = corner_q;
    last     = !status_i.found || (corner_q == LAST_CORNER);
    cmd_o    = '0;
    cmd_o.corner = corner_q;
    cmd_o.last   = last;
    unique case (state_q)
      ST_RUN: begin
        cmd_o.take = 1'b1;
        if (status_i.end_accept) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_PREP;
        else cmd_o.div_step = 1'b1;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        corner_d   = '0;
        state_d    = ST_MULA;
      end
      ST_MULA: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_MULB;
      end
      ST_MULB: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (last) begin
            state_d = ST_RUN;
          end else begin
            corner_d = corner_q + 2'd1;
            state_d  = ST_MULA;
          end
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RUN;
      corner_q <= '0;
    end else begin
      state_q  <= state_d;
      corner_q <= corner_d;
    end
  end

endmodule

>>> src/upgd_checker.sv
// Port-level checks for the parking gap detector, bound to the top level.
// Depends on upgd_pkg and ultrasonic_parking_gap_detector_assert.svh.
`include "ultrasonic_parking_gap_detector_assert.svh"

module upgd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            s_axis_tlast_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [upgd_pkg::TDATA_W-1:0]    m_axis_tdata_o,
  input logic [upgd_pkg::TUSER_W-1:0]    m_axis_tuser_o,
  input logic                            m_axis_tlast_o
);
  import upgd_pkg::*;

  // stalled result must hold
  `UPGD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // end of scan closes the input channel for the result work
  `UPGD_ASSERT_NXT(a_end_stalls_in, clk_i, rst_ni,
                   s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, !s_axis_tready_o)

  // a no-slot result is a single transfer for corner zero
  `UPGD_ASSERT_IMP(a_not_found_single, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0],
                   m_axis_tlast_o && (m_axis_tuser_o[2:1] == 2'd0))

  // a slot ends on its fourth corner
  `UPGD_ASSERT_IMP(a_found_last_corner, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0],
                   m_axis_tlast_o == (m_axis_tuser_o[2:1] == LAST_CORNER))

endmodule

bind ultrasonic_parking_gap_detector upgd_checker u_upgd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_parking_gap_detector: sensor scans in, slot corners out.
// Predicts every corner transfer in-line; depends on upgd_pkg and the block's RTL only.
module testbench;
  import upgd_pkg::*;

  localparam int MAX_READS    = 1024;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int NUM_PHASES   = 7;
  localparam int PHASE_ITEMS  = 80;
  localparam int LOG_LIMIT    = 10;
  localparam int MIN_SLOT     = 5;
  localparam int RANGE_MM     = 10000;
  localparam int ROT_Q16      = 46341;   // sqrt(2)/2 in Q16

  localparam logic [1:0] SLOT_DIAGONAL = 2'd2;
  localparam logic [1:0] SLOT_SPARE    = 2'd3;   // decodes as diagonal
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic        found;
    logic [16:0] slot_width;
    logic [13:0] slot_depth;
    logic [17:0] center_along;
    logic [14:0] center_lateral;
    logic [1:0]  corner_index;
    logic [19:0] corner_along;
    logic [19:0] corner_lateral;
    logic        last_of_run;
  } slot_corner_t;

  typedef enum logic [1:0] {
    EXP_NONE,
    EXP_NOT_FOUND,
    EXP_MODEL
  } exp_kind_e;

  typedef struct packed {
    logic [15:0] dist_mm;
    logic        scan_end;
    exp_kind_e   kind;
  } probe_t;

  localparam slot_corner_t NO_SLOT = '{1'b0, 17'd0, 14'd0, 18'd0, 15'd0, 2'd0, 20'd0, 20'd0, 1'b1};

  // default config: threshold 2000, parallel, vehicle width 1800
  localparam probe_t DIR_TAB [0:23] = '{
    '{16'd0,     1'b1, EXP_NOT_FOUND},  // lone obstacle reading
    '{16'd65535, 1'b1, EXP_NOT_FOUND},  // lone free reading, too short
    '{16'd65535, 1'b0, EXP_NONE},       // run of five, mixed in/out of range
    '{16'd10000, 1'b0, EXP_NONE},
    '{16'd9999,  1'b0, EXP_NONE},
    '{16'd2001,  1'b0, EXP_NONE},
    '{16'd65535, 1'b0, EXP_NONE},
    '{16'd2000,  1'b1, EXP_MODEL},      // equal to threshold closes the run
    '{16'd3000,  1'b0, EXP_NONE},       // two runs of five, earliest wins
    '{16'd3000,  1'b0, EXP_NONE},
    '{16'd3000,  1'b0, EXP_NONE},
    '{16'd3000,  1'b0, EXP_NONE},
    '{16'd3000,  1'b0, EXP_NONE},
    '{16'd1999,  1'b0, EXP_NONE},
    '{16'd9999,  1'b0, EXP_NONE},
    '{16'd9999,  1'b0, EXP_NONE},
    '{16'd9999,  1'b0, EXP_NONE},
    '{16'd9999,  1'b0, EXP_NONE},
    '{16'd9999,  1'b1, EXP_MODEL},      // run still open at end of scan
    '{16'd2001,  1'b0, EXP_NONE},       // run of four
    '{16'd2001,  1'b0, EXP_NONE},
    '{16'd2001,  1'b0, EXP_NONE},
    '{16'd2001,  1'b0, EXP_NONE},
    '{16'd0,     1'b1, EXP_NOT_FOUND}
  };

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [DIST_W-1:0]     in_dist   = '0;
  logic                  in_end    = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [TDATA_W-1:0]    out_data;
  logic [TUSER_W-1:0]    out_user;
  logic                  out_last;

  ultrasonic_parking_gap_detector #(
    .MAX_READINGS(MAX_READS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_dist),
    .s_axis_tlast_i  (in_end),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_user),
    .m_axis_tlast_o  (out_last)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---- slot predictor state ----
  logic [15:0] thr_q;
  logic [1:0]  type_q;
  logic [12:0] vw_q;
  logic [10:0] scan_idx;
  logic        in_run;
  logic [9:0]  run_first;
  logic [10:0] run_len;
  logic [23:0] run_acc;
  logic [10:0] run_cnt;
  logic [9:0]  best_first;
  logic [10:0] best_len;
  logic [23:0] best_acc;
  logic [10:0] best_cnt;

  int par_sx [4] = '{-1, 1, 1, -1};
  int par_sy [4] = '{-1, -1, 1, 1};
  int per_sx [4] = '{-1, -1, 1, 1};
  int per_sy [4] = '{-1, 1, 1, -1};

  slot_corner_t corners_due[$];
  slot_corner_t got, want;
  int bad_results = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_left  = 0;
  int stall_tick  = 0;

  task automatic clear_scan_state();
    scan_idx   = '0;
    in_run     = 1'b0;
    run_first  = '0;
    run_len    = '0;
    run_acc    = '0;
    run_cnt    = '0;
    best_first = '0;
    best_len   = '0;
    best_acc   = '0;
    best_cnt   = '0;
  endtask

  task automatic close_gap_run();
    if (in_run && run_len > best_len) begin
      best_first = run_first;
      best_len   = run_len;
      best_acc   = run_acc;
      best_cnt   = run_cnt;
    end
    in_run = 1'b0;
  endtask

  // round to nearest, ties up: arithmetic shift floors
  function automatic longint rotate_q16(longint v);
    return (v * ROT_Q16 + 32768) >>> 16;
  endfunction

  task automatic predict_reading(input logic [15:0] dist_mm, input logic scan_end);
    longint width, depth, cx, cy, dx, dy, ax, ay;
    slot_corner_t r;
    int k;
    if (scan_idx < MAX_READS) begin
      if (dist_mm > thr_q) begin
        if (!in_run) begin
          in_run    = 1'b1;
          run_first = scan_idx[9:0];
          run_len   = '0;
          run_acc   = '0;
          run_cnt   = '0;
        end
        run_len++;
        if (dist_mm < RANGE_MM) begin
          run_acc += dist_mm;
          run_cnt++;
        end
      end else begin
        close_gap_run();
      end
      scan_idx++;
    end
    if (!scan_end) return;
    close_gap_run();
    if (best_len < MIN_SLOT) begin
      corners_due.push_back(NO_SLOT);
    end else begin
      width = longint'(best_len) * 100;
      depth = (best_cnt != 0) ? longint'(best_acc / best_cnt) : 0;
      cx    = (longint'(best_first) + longint'(best_len / 2)) * 200;
      cy    = longint'(vw_q) + depth;
      for (k = 0; k < 4; k++) begin
        if (type_q == SLOT_PARALLEL) begin
          ax = cx + par_sx[k] * width;
          ay = cy + par_sy[k] * depth;
        end else begin
          dx = per_sx[k] * width;
          dy = per_sy[k] * depth;
          if (type_q == SLOT_PERPENDICULAR) begin
            ax = cx + dx;
            ay = cy + dy;
          end else begin
            ax = cx + rotate_q16(dx - dy);
            ay = cy + rotate_q16(dx + dy);
          end
        end
        r.found          = 1'b1;
        r.slot_width     = width[16:0];
        r.slot_depth     = depth[13:0];
        r.center_along   = cx[17:0];
        r.center_lateral = cy[14:0];
        r.corner_index   = k[1:0];
        r.corner_along   = ax[19:0];
        r.corner_lateral = ay[19:0];
        r.last_of_run    = (k == 3);
        corners_due.push_back(r);
      end
    end
    clear_scan_state();
  endtask

  // ---- output checking ----
  function automatic bit field_differs(string name, logic [19:0] exp_v, logic [19:0] act_v);
    if (exp_v === act_v) return 1'b0;
    if (bad_results < LOG_LIMIT)
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
    return 1'b1;
  endfunction

  task automatic check_corner(input slot_corner_t exp_r, input slot_corner_t act_r);
    bit bad;
    bad = 1'b0;
    bad |= field_differs("found", exp_r.found, act_r.found);
    bad |= field_differs("slot_width", exp_r.slot_width, act_r.slot_width);
    bad |= field_differs("slot_depth", exp_r.slot_depth, act_r.slot_depth);
    bad |= field_differs("center_along", exp_r.center_along, act_r.center_along);
    bad |= field_differs("center_lateral", exp_r.center_lateral, act_r.center_lateral);
    bad |= field_differs("corner_index", exp_r.corner_index, act_r.corner_index);
    bad |= field_differs("corner_along", exp_r.corner_along, act_r.corner_along);
    bad |= field_differs("corner_lateral", exp_r.corner_lateral, act_r.corner_lateral);
    bad |= field_differs("last_of_run", exp_r.last_of_run, act_r.last_of_run);
    if (bad) bad_results++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      got = '{out_user[0], out_data[16:0], out_data[30:17], out_data[48:31], out_data[63:49],
              out_user[2:1], out_data[83:64], out_data[103:84], out_last};
      if (corners_due.size() == 0) begin
        if (bad_results < LOG_LIMIT)
          $display("%0t: unexpected output transfer, data %h user %h", $realtime, out_data,
                   out_user);
        bad_results++;
      end else begin
        want = corners_due.pop_front();
        check_corner(want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: always ready, coin flip, one in four, or long stalls
  always @(negedge clk_i) begin
    stall_tick++;
    if (stall_tick % 96 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_tick % 4 == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(3, 12);
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // ---- stimulus ----
  task automatic send_reading(input logic [15:0] dist_mm, input logic scan_end,
                              input exp_kind_e kind);
    int idle;
    int n_before;
    if (burst_left == 0) begin
      idle       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_dist  <= dist_mm;
    in_end   <= scan_end;
    do @(posedge clk_i); while (!in_ready);
    n_before = corners_due.size();
    predict_reading(dist_mm, scan_end);
    if (kind == EXP_NOT_FOUND) begin
      while (corners_due.size() > n_before) void'(corners_due.pop_back());
      corners_due.push_back(NO_SLOT);
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    in_end   <= 1'b0;
    while (corners_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    burst_left = 0;
  endtask

  // all writes in one back-to-back burst, so write enable stays high throughout
  task automatic configure(input logic [15:0] thr, input logic [1:0] kind, input logic [12:0] vw);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_UNUSED;
    cfg_wdata <= 16'($urandom);
    @(negedge clk_i);
    cfg_idx   <= CFG_GAP_THRESHOLD;
    cfg_wdata <= thr;
    @(negedge clk_i);
    cfg_idx   <= CFG_SLOT_TYPE;
    cfg_wdata <= {14'($urandom), kind};
    @(negedge clk_i);
    cfg_idx   <= CFG_VEHICLE_WIDTH;
    cfg_wdata <= {3'($urandom), vw};
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    thr_q  = thr;
    type_q = kind;
    vw_q   = vw;
  endtask

  function automatic logic [15:0] free_reading();
    int lo;
    lo = int'(thr_q) + 1;
    if (lo > 65535) return 16'hFFFF;  // nothing is free at the top threshold
    case ($urandom_range(0, 7))
      0: return lo[15:0];
      1: return 16'hFFFF;
      2: return 16'($urandom_range(lo, 65535));
      3: return (lo <= RANGE_MM) ? 16'(RANGE_MM) : lo[15:0];
      default: begin
        if (lo < RANGE_MM) return 16'($urandom_range(lo, RANGE_MM - 1));
        return 16'($urandom_range(lo, 65535));
      end
    endcase
  endfunction

  function automatic logic [15:0] blocked_reading();
    case ($urandom_range(0, 3))
      0: return thr_q;
      1: return 16'd0;
      default: return 16'($urandom_range(0, int'(thr_q)));
    endcase
  endfunction

  task automatic random_scan(inout int budget);
    int shape, total, seg, i, prev_gap;
    bit free;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      total = $urandom_range(1, 40);
      for (i = 0; i < total; i++) send_reading(16'($urandom), i == total - 1, EXP_MODEL);
    end else if (shape == 1) begin
      total = $urandom_range(1, 4);
      for (i = 0; i < total; i++) send_reading(free_reading(), i == total - 1, EXP_MODEL);
    end else begin
      // alternating obstacle and gap runs; gaps often repeat the last length to force ties
      total    = $urandom_range(6, 48);
      i        = 0;
      prev_gap = MIN_SLOT;
      free     = 1'($urandom_range(0, 1));
      while (i < total) begin
        if (free) begin
          seg      = ($urandom_range(0, 3) == 0) ? prev_gap : $urandom_range(3, 12);
          prev_gap = seg;
        end else begin
          seg = $urandom_range(1, 6);
        end
        repeat (seg) begin
          if (i < total)
            send_reading(free ? free_reading() : blocked_reading(), i == total - 1, EXP_MODEL);
          i++;
        end
        free = !free;
      end
    end
    budget -= total;
  endtask

  // scan past MAX_READS: a run straddles the limit, later readings are ignored
  task automatic overflow_scan();
    int i, gap_from, stop;
    gap_from = MAX_READS - $urandom_range(3, 9);
    stop     = MAX_READS + $urandom_range(2, 24);
    for (i = 0; i < stop; i++) begin
      if (i >= MAX_READS)
        send_reading(16'($urandom), i == stop - 1, EXP_MODEL);
      else if (i >= gap_from || (i >= 100 && i < 106))
        send_reading(free_reading(), 1'b0, EXP_MODEL);
      else
        send_reading(blocked_reading(), 1'b0, EXP_MODEL);
    end
  endtask

  initial begin
    int p, row, budget;
    thr_q  = GAP_THRESHOLD_RST;
    type_q = SLOT_TYPE_RST;
    vw_q   = VEHICLE_WIDTH_RST;
    clear_scan_state();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (row = 0; row < 24; row++)
      send_reading(DIR_TAB[row].dist_mm, DIR_TAB[row].scan_end, DIR_TAB[row].kind);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      budget = PHASE_ITEMS;
      case (p)
        0: configure(16'd0, SLOT_PARALLEL, 13'd8191);
        1: begin
          configure(16'd65535, SLOT_PERPENDICULAR, 13'd0);
          budget = 20;
        end
        2: configure(16'($urandom_range(500, 4000)), SLOT_DIAGONAL, 13'($urandom));
        3: configure(16'($urandom_range(500, 4000)), SLOT_SPARE, 13'($urandom));
        4: configure(16'd9999, SLOT_PERPENDICULAR, 13'($urandom));
        5: configure(16'($urandom_range(0, 65535)), 2'($urandom), 13'($urandom));
        default: configure(16'($urandom_range(200, 3000)), SLOT_PARALLEL, 13'($urandom));
      endcase
      if (p == 2) overflow_scan();
      while (budget > 0) random_scan(budget);
      drain();
    end

    if (bad_results == 0 && corners_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
